// ----- hdl/jsu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and helpers for the joint stress utilisation block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int FRIC_W    = 16;
    localparam int FRIC_FRAC = 12;
    localparam int STRESS_W  = 56;
    localparam int HALF_W    = STRESS_W / 2;
    localparam int QUO_W     = STRESS_W + 1;
    localparam int NUM_W     = 128;
    localparam int DEN_W     = 64;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int FSUM_W    = FRIC_W + STRESS_W;
    localparam int ADDR_W    = 5;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_COMP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TENS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FRIC  = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAXSH = 3'd4;
    localparam logic [IDX_W-1:0] REG_FORCE = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] comp;
        logic [DATA_W-1:0] tens;
        logic [DATA_W-1:0] coh;
        logic [FRIC_W-1:0] fric;
        logic [DATA_W-1:0] maxsh;
        logic [DATA_W-1:0] force_scale;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]        tension_force;
        logic [DATA_W-1:0]        compression_force;
        logic [DATA_W-1:0]        shear_force;
        logic signed [DATA_W-1:0] moment_u;
        logic signed [DATA_W-1:0] moment_v;
        logic [DATA_W-1:0]        interface_area;
        logic [DATA_W-1:0]        modulus_u;
        logic [DATA_W-1:0]        modulus_v;
        logic [DATA_W-1:0]        composite_modulus_u;
        logic [DATA_W-1:0]        composite_modulus_v;
    } item_t;

    typedef struct packed {
        logic [STRESS_W-1:0] su;
        logic [STRESS_W-1:0] sv;
        logic [STRESS_W-1:0] nmag;
        logic [STRESS_W-1:0] mc;
        logic [STRESS_W-1:0] ss;
        logic [STRESS_W-1:0] cbu;
        logic [STRESS_W-1:0] cbv;
        logic                fail;
        logic                bu;
        logic                bv;
        logic                nneg;
        logic                cu_nz;
        logic                cv_nz;
    } stress_t;

    typedef struct packed {
        logic [STRESS_W-1:0] pc;
        logic [STRESS_W-1:0] pt;
        logic [STRESS_W-1:0] mc;
        logic [STRESS_W-1:0] ss;
        logic                fail;
    } relief_t;

    function automatic logic [STRESS_W-1:0] clamp_stress(input logic [QUO_W-1:0] q);
        return q[QUO_W-1] ? {STRESS_W{1'b1}} : q[STRESS_W-1:0];
    endfunction

    function automatic logic [STRESS_W-1:0] sat_add(input logic [STRESS_W-1:0] a,
                                                   input logic [STRESS_W-1:0] b);
        logic [STRESS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STRESS_W] ? {STRESS_W{1'b1}} : s[STRESS_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] clamp_ratio(input logic [QUO_W-1:0] q);
        return (q[QUO_W-1:DATA_W] != '0) ? {DATA_W{1'b1}} : q[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/joint_stress_utilisation_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// joint_stress_utilisation_top
// Worst stress-to-capacity ratio of a masonry joint, fully pipelined.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    ten load and section fields
//   result    out        result_valid / result_stall utilisation, failed_closed
//   config    in         apb psel/penable/pwrite    six capacity registers
//
// one item per cycle while item_stall is low
// the path runs through three chained levels of 57-stage restoring dividers
// reset clears all valid bits and loads register defaults
// result side holds one item plus a skid entry; item_stall rises when the
// skid entry is full and the whole pipeline then holds
// ----------------------------------------------------------------------------
module joint_stress_utilisation_top
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [DATA_W-1:0] tension_force,
    input  logic [DATA_W-1:0] compression_force,
    input  logic [DATA_W-1:0] shear_force,
    input  logic signed [DATA_W-1:0] moment_u,
    input  logic signed [DATA_W-1:0] moment_v,
    input  logic [DATA_W-1:0] interface_area,
    input  logic [DATA_W-1:0] modulus_u,
    input  logic [DATA_W-1:0] modulus_v,
    input  logic [DATA_W-1:0] composite_modulus_u,
    input  logic [DATA_W-1:0] composite_modulus_v,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [DATA_W-1:0] utilisation,
    output logic              failed_closed
);

    cfg_t              cfg_reg;
    item_t             item;
    stress_t           stress;
    relief_t           relief;
    logic              en, front_v, relief_v, ratio_v;
    logic [DATA_W-1:0] ratio_util;
    logic              ratio_fail;
    logic [IDX_W-1:0]  widx;
    logic              wr;

    logic              out_v_reg, skid_v_reg, taken;
    logic [DATA_W-1:0] out_util_reg, skid_util_reg;
    logic              out_fail_reg, skid_fail_reg;

    assign pready = 1'b1;
    assign widx   = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comp        <= '0;
            cfg_reg.tens        <= '0;
            cfg_reg.coh         <= '0;
            cfg_reg.fric        <= '0;
            cfg_reg.maxsh       <= '1;
            cfg_reg.force_scale <= DATA_W'(1) << FRAC_BITS;
        end
        else if (wr)
        begin
            case (widx)
                REG_COMP:  cfg_reg.comp        <= pwdata;
                REG_TENS:  cfg_reg.tens        <= pwdata;
                REG_COH:   cfg_reg.coh         <= pwdata;
                REG_FRIC:  cfg_reg.fric        <= pwdata[FRIC_W-1:0];
                REG_MAXSH: cfg_reg.maxsh       <= pwdata;
                REG_FORCE: cfg_reg.force_scale <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_COMP:  prdata = cfg_reg.comp;
            REG_TENS:  prdata = cfg_reg.tens;
            REG_COH:   prdata = cfg_reg.coh;
            REG_FRIC:  prdata = DATA_W'(cfg_reg.fric);
            REG_MAXSH: prdata = cfg_reg.maxsh;
            REG_FORCE: prdata = cfg_reg.force_scale;
            default:   prdata = '0;
        endcase
    end

    assign item.tension_force       = tension_force;
    assign item.compression_force   = compression_force;
    assign item.shear_force         = shear_force;
    assign item.moment_u            = moment_u;
    assign item.moment_v            = moment_v;
    assign item.interface_area      = interface_area;
    assign item.modulus_u           = modulus_u;
    assign item.modulus_v           = modulus_v;
    assign item.composite_modulus_u = composite_modulus_u;
    assign item.composite_modulus_v = composite_modulus_v;

    assign en         = !skid_v_reg;
    assign item_stall = skid_v_reg;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (item_valid),
        .item   (item),
        .cfg    (cfg_reg),
        .out_v  (front_v),
        .stress (stress)
    );

    jsu_relief u_relief (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (front_v),
        .stress (stress),
        .cfg    (cfg_reg),
        .out_v  (relief_v),
        .relief (relief)
    );

    jsu_ratio u_ratio (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (relief_v),
        .relief (relief),
        .cfg    (cfg_reg),
        .out_v  (ratio_v),
        .util   (ratio_util),
        .failed (ratio_fail)
    );

    assign taken = out_v_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (taken)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (ratio_v)
        begin
            if (out_v_reg && !taken)
            begin
                skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= 1'b1;
            end
        end
        else if (taken)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (taken)
            begin
                out_util_reg <= skid_util_reg;
                out_fail_reg <= skid_fail_reg;
            end
        end
        else if (ratio_v)
        begin
            if (out_v_reg && !taken)
            begin
                skid_util_reg <= ratio_util;
                skid_fail_reg <= ratio_fail;
            end
            else
            begin
                out_util_reg <= ratio_util;
                out_fail_reg <= ratio_fail;
            end
        end
    end

    assign result_valid  = out_v_reg;
    assign utilisation   = out_util_reg;
    assign failed_closed = out_fail_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without an output item");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && result_stall) |=> skid_v_reg)
        else $error("skid entry dropped while result stalled");

    a_fail_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_fail_reg) |-> (out_util_reg == {DATA_W{1'b1}}))
        else $error("failed item without saturated utilisation");

endmodule
`default_nettype wire

// ----- hdl/jsu_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_div
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// ----------------------------------------------------------------------------
module jsu_div
    import jsu_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];
    logic [QUO_W-1:0] acc_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];

    logic [NUM_W-QUO_W-1:0] head;
    logic                   ovf_next;

    assign head     = num[NUM_W-1:QUO_W];
    assign ovf_next = (den == '0) || (head >= (NUM_W-QUO_W)'(den));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf_next ? '0 : head[DEN_W-1:0];
            den_reg[0] <= den;
            acc_reg[0] <= num[QUO_W-1:0];
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[g], acc_reg[g][QUO_W-1]};
        assign diff  = trial - {1'b0, den_reg[g]};
        assign ge    = trial >= {1'b0, den_reg[g]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[g+1] <= {acc_reg[g][QUO_W-2:0], ge};
                ovf_reg[g+1] <= ovf_reg[g];
            end
        end

        if (g < QUO_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    den_reg[g+1] <= den_reg[g];
                end
            end
        end
    end

    assign quo = ovf_reg[QUO_W] ? {QUO_W{1'b1}} : acc_reg[QUO_W];

endmodule
`default_nettype wire

// ----- hdl/jsu_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Load magnitudes, scaled moduli and the seven base stresses.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_v,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    out_v,
    output stress_t stress
);

    typedef struct packed {
        logic [DATA_W-1:0] mu;
        logic [DATA_W-1:0] mv;
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] sh;
        logic [DATA_W-1:0] wu;
        logic [DATA_W-1:0] wv;
        logic [DATA_W-1:0] area;
        logic [DATA_W-1:0] cu;
        logic [DATA_W-1:0] cv;
        logic [DATA_W-1:0] k;
        logic              fail;
        logic              bu;
        logic              bv;
        logic              nneg;
    } a0_t;

    typedef struct packed {
        logic [DATA_W-1:0] mu;
        logic [DATA_W-1:0] mv;
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] sh;
        logic [DEN_W-1:0]  wuk;
        logic [DEN_W-1:0]  wvk;
        logic [DEN_W-1:0]  ak;
        logic [DEN_W-1:0]  cuk;
        logic [DEN_W-1:0]  cvk;
        logic              fail;
        logic              bu;
        logic              bv;
        logic              nneg;
        logic              cu_nz;
        logic              cv_nz;
    } a1_t;

    typedef struct packed {
        logic fail;
        logic bu;
        logic bv;
        logic nneg;
        logic cu_nz;
        logic cv_nz;
    } side_t;

    a0_t                a0_next, a0_reg;
    a1_t                a1_next, a1_reg;
    logic               a0_v_reg, a1_v_reg;
    side_t              side_reg [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] sv_reg;
    stress_t            st_next, st_reg;
    logic               st_v_reg;

    logic [QUO_W-1:0] q_su, q_sv, q_n, q_mc, q_ss, q_cbu, q_cbv;

    always_comb
    begin
        a0_next.mu   = item.moment_u[DATA_W-1] ? (~item.moment_u + 1'b1) : item.moment_u;
        a0_next.mv   = item.moment_v[DATA_W-1] ? (~item.moment_v + 1'b1) : item.moment_v;
        a0_next.nneg = item.compression_force > item.tension_force;
        a0_next.diff = a0_next.nneg ? (item.compression_force - item.tension_force)
                                    : (item.tension_force - item.compression_force);
        a0_next.c    = item.compression_force;
        a0_next.sh   = item.shear_force;
        a0_next.wu   = item.modulus_u;
        a0_next.wv   = item.modulus_v;
        a0_next.area = item.interface_area;
        a0_next.cu   = item.composite_modulus_u;
        a0_next.cv   = item.composite_modulus_v;
        a0_next.k    = (cfg.force_scale == '0) ? DATA_W'(1) : cfg.force_scale;
        a0_next.bu   = item.moment_u != '0;
        a0_next.bv   = item.moment_v != '0;
        a0_next.fail = (item.interface_area == '0)
                    || (a0_next.bu && item.modulus_u == '0)
                    || (a0_next.bv && item.modulus_v == '0);
    end

    always_comb
    begin
        a1_next.mu    = a0_reg.mu;
        a1_next.mv    = a0_reg.mv;
        a1_next.diff  = a0_reg.diff;
        a1_next.c     = a0_reg.c;
        a1_next.sh    = a0_reg.sh;
        a1_next.wuk   = a0_reg.wu * a0_reg.k;
        a1_next.wvk   = a0_reg.wv * a0_reg.k;
        a1_next.ak    = a0_reg.area * a0_reg.k;
        a1_next.cuk   = a0_reg.cu * a0_reg.k;
        a1_next.cvk   = a0_reg.cv * a0_reg.k;
        a1_next.fail  = a0_reg.fail;
        a1_next.bu    = a0_reg.bu;
        a1_next.bv    = a0_reg.bv;
        a1_next.nneg  = a0_reg.nneg;
        a1_next.cu_nz = a0_reg.cu != '0;
        a1_next.cv_nz = a0_reg.cv != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_v_reg <= 1'b0;
            a1_v_reg <= 1'b0;
            sv_reg   <= '0;
            st_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a0_v_reg <= in_v;
            a1_v_reg <= a0_v_reg;
            sv_reg   <= {sv_reg[DIV_LAT-2:0], a1_v_reg};
            st_v_reg <= sv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg            <= a0_next;
            a1_reg            <= a1_next;
            side_reg[0].fail  <= a1_reg.fail;
            side_reg[0].bu    <= a1_reg.bu;
            side_reg[0].bv    <= a1_reg.bv;
            side_reg[0].nneg  <= a1_reg.nneg;
            side_reg[0].cu_nz <= a1_reg.cu_nz;
            side_reg[0].cv_nz <= a1_reg.cv_nz;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            st_reg <= st_next;
        end
    end

    jsu_div u_div_su (.clk(clk), .en(en), .num(NUM_W'(a1_reg.mu) << (2*FRAC_BITS)),
                      .den(a1_reg.wuk), .quo(q_su));
    jsu_div u_div_sv (.clk(clk), .en(en), .num(NUM_W'(a1_reg.mv) << (2*FRAC_BITS)),
                      .den(a1_reg.wvk), .quo(q_sv));
    jsu_div u_div_n  (.clk(clk), .en(en), .num(NUM_W'(a1_reg.diff) << (2*FRAC_BITS)),
                      .den(a1_reg.ak), .quo(q_n));
    jsu_div u_div_mc (.clk(clk), .en(en), .num(NUM_W'(a1_reg.c) << (2*FRAC_BITS)),
                      .den(a1_reg.ak), .quo(q_mc));
    jsu_div u_div_ss (.clk(clk), .en(en), .num(NUM_W'(a1_reg.sh) << (2*FRAC_BITS)),
                      .den(a1_reg.ak), .quo(q_ss));
    jsu_div u_div_cu (.clk(clk), .en(en), .num(NUM_W'(a1_reg.mu) << (2*FRAC_BITS)),
                      .den(a1_reg.cuk), .quo(q_cbu));
    jsu_div u_div_cv (.clk(clk), .en(en), .num(NUM_W'(a1_reg.mv) << (2*FRAC_BITS)),
                      .den(a1_reg.cvk), .quo(q_cbv));

    always_comb
    begin
        st_next.su    = side_reg[DIV_LAT-1].bu ? clamp_stress(q_su) : '0;
        st_next.sv    = side_reg[DIV_LAT-1].bv ? clamp_stress(q_sv) : '0;
        st_next.nmag  = clamp_stress(q_n);
        st_next.mc    = clamp_stress(q_mc);
        st_next.ss    = clamp_stress(q_ss);
        st_next.cbu   = side_reg[DIV_LAT-1].bu ? clamp_stress(q_cbu) : '0;
        st_next.cbv   = side_reg[DIV_LAT-1].bv ? clamp_stress(q_cbv) : '0;
        st_next.fail  = side_reg[DIV_LAT-1].fail;
        st_next.bu    = side_reg[DIV_LAT-1].bu;
        st_next.bv    = side_reg[DIV_LAT-1].bv;
        st_next.nneg  = side_reg[DIV_LAT-1].nneg;
        st_next.cu_nz = side_reg[DIV_LAT-1].cu_nz;
        st_next.cv_nz = side_reg[DIV_LAT-1].cv_nz;
    end

    assign out_v  = st_v_reg;
    assign stress = st_reg;

endmodule
`default_nettype wire

// ----- hdl/jsu_relief.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_relief
// Edge stresses, dry-joint partial contact relief and composite relief.
// ----------------------------------------------------------------------------
module jsu_relief
    import jsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_v,
    input  stress_t stress,
    input  cfg_t    cfg,
    output logic    out_v,
    output relief_t relief
);

    typedef struct packed {
        logic [STRESS_W-1:0] pt;
        logic [STRESS_W-1:0] pc;
        logic [STRESS_W-1:0] bc;
        logic [STRESS_W-1:0] bo;
        logic [STRESS_W+1:0] m3;
        logic [STRESS_W-1:0] n;
        logic [STRESS_W-1:0] cb;
        logic [STRESS_W-1:0] mc;
        logic [STRESS_W-1:0] ss;
        logic                comp_en;
        logic                pc_try;
        logic                nneg;
        logic                fail;
    } b0_t;

    typedef struct packed {
        logic [STRESS_W-1:0] pt;
        logic [STRESS_W-1:0] pc;
        logic [STRESS_W-1:0] bo;
        logic [STRESS_W-1:0] n;
        logic [STRESS_W-1:0] cb;
        logic [STRESS_W-1:0] mc;
        logic [STRESS_W-1:0] ss;
        logic                comp_en;
        logic                rel_ok;
        logic                nneg;
        logic                fail;
    } side_t;

    typedef struct packed {
        logic [2*HALF_W-1:0] phh;
        logic [2*HALF_W-1:0] phl;
        logic [2*HALF_W-1:0] pll;
        logic [STRESS_W+1:0] den;
    } b1_t;

    b0_t                b0_next, b0_reg;
    side_t              s1_next, s1_reg, s2_reg;
    b1_t                b1_next, b1_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    side_t              side_reg [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] sv_reg;
    side_t              b3_next, b3_reg;
    relief_t            b4_next, b4_reg;
    logic               b0_v_reg, b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    logic [QUO_W-1:0]   q_rel;
    logic [STRESS_W-1:0] bend, nm;
    logic               ku, kv;

    always_comb
    begin
        bend = sat_add(stress.su, stress.sv);
        ku   = stress.su > stress.nmag;
        kv   = stress.sv > stress.nmag;
        b0_next.n  = stress.nmag;
        if (stress.nneg)
        begin
            b0_next.pt = (bend > stress.nmag) ? (bend - stress.nmag) : '0;
            b0_next.pc = sat_add(bend, stress.nmag);
        end
        else
        begin
            b0_next.pt = sat_add(bend, stress.nmag);
            b0_next.pc = (bend > stress.nmag) ? (bend - stress.nmag) : '0;
        end
        b0_next.bc      = ku ? stress.su : stress.sv;
        b0_next.bo      = ku ? stress.sv : stress.su;
        b0_next.m3      = {2'b00, stress.nmag} + {1'b0, stress.nmag, 1'b0};
        b0_next.cb      = sat_add(stress.cbu, stress.cbv);
        b0_next.mc      = stress.mc;
        b0_next.ss      = stress.ss;
        b0_next.comp_en = (stress.bu || stress.bv) && (!stress.bu || stress.cu_nz)
                       && (!stress.bv || stress.cv_nz);
        b0_next.pc_try  = (cfg.tens == '0) && stress.nneg && (stress.nmag != '0)
                       && (b0_next.pt != '0) && (ku != kv);
        b0_next.nneg    = stress.nneg;
        b0_next.fail    = stress.fail;
    end

    always_comb
    begin
        s1_next.pt      = b0_reg.pt;
        s1_next.pc      = b0_reg.pc;
        s1_next.bo      = b0_reg.bo;
        s1_next.n       = b0_reg.n;
        s1_next.cb      = b0_reg.cb;
        s1_next.mc      = b0_reg.mc;
        s1_next.ss      = b0_reg.ss;
        s1_next.comp_en = b0_reg.comp_en;
        s1_next.rel_ok  = b0_reg.pc_try && ({2'b00, b0_reg.bc} < b0_reg.m3);
        s1_next.nneg    = b0_reg.nneg;
        s1_next.fail    = b0_reg.fail;
        b1_next.den     = b0_reg.m3 - {2'b00, b0_reg.bc};
        b1_next.phh     = b0_reg.n[STRESS_W-1:HALF_W] * b0_reg.n[STRESS_W-1:HALF_W];
        b1_next.phl     = b0_reg.n[STRESS_W-1:HALF_W] * b0_reg.n[HALF_W-1:0];
        b1_next.pll     = b0_reg.n[HALF_W-1:0] * b0_reg.n[HALF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg <= 1'b0;
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            sv_reg   <= '0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_v_reg <= in_v;
            b1_v_reg <= b0_v_reg;
            b2_v_reg <= b1_v_reg;
            sv_reg   <= {sv_reg[DIV_LAT-2:0], b2_v_reg};
            b3_v_reg <= sv_reg[DIV_LAT-1];
            b4_v_reg <= b3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_reg  <= b0_next;
            s1_reg  <= s1_next;
            b1_reg  <= b1_next;
            s2_reg  <= s1_reg;
            num_reg <= (NUM_W'(b1_reg.phh) << (2*HALF_W + 2))
                     + (NUM_W'(b1_reg.phl) << (HALF_W + 3))
                     + (NUM_W'(b1_reg.pll) << 2);
            den_reg <= DEN_W'(b1_reg.den);
            side_reg[0] <= s2_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            b3_reg <= b3_next;
            b4_reg <= b4_next;
        end
    end

    jsu_div u_div_rel (.clk(clk), .en(en), .num(num_reg), .den(den_reg), .quo(q_rel));

    always_comb
    begin
        b3_next = side_reg[DIV_LAT-1];
        if (side_reg[DIV_LAT-1].rel_ok)
        begin
            b3_next.pt = '0;
            b3_next.pc = sat_add(clamp_stress(q_rel), side_reg[DIV_LAT-1].bo);
        end
    end

    // composite deep-beam relief
    always_comb
    begin
        nm          = b3_reg.nneg ? b3_reg.n : '0;
        b4_next.pc  = b3_reg.pc;
        b4_next.pt  = b3_reg.pt;
        b4_next.mc  = b3_reg.mc;
        b4_next.ss  = b3_reg.ss;
        b4_next.fail = b3_reg.fail;
        if (b3_reg.comp_en && (b3_reg.nneg || b3_reg.n == '0) && (b3_reg.cb < b3_reg.pt))
        begin
            b4_next.pt = b3_reg.cb;
            b4_next.pc = (b3_reg.cb > nm) ? b3_reg.cb : nm;
        end
    end

    assign out_v  = b4_v_reg;
    assign relief = b4_reg;

endmodule
`default_nettype wire

// ----- hdl/jsu_ratio.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_ratio
// Mohr-Coulomb shear capacity, three capacity ratios and the worst of them.
// ----------------------------------------------------------------------------
module jsu_ratio
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_v,
    input  relief_t           relief,
    input  cfg_t              cfg,
    output logic              out_v,
    output logic [DATA_W-1:0] util,
    output logic              failed
);

    typedef struct packed {
        logic [STRESS_W-1:0] pc;
        logic [STRESS_W-1:0] pt;
        logic [STRESS_W-1:0] ss;
        logic                fail;
    } pass_t;

    typedef struct packed {
        logic fail;
        logic cs_nz;
        logic sc_nz;
        logic ts_nz;
    } side_t;

    pass_t                  c0_reg, c1_reg, c2_reg;
    logic [FRIC_W+HALF_W-1:0] pfh_reg, pfl_reg;
    logic [FSUM_W-1:0]      fsum_reg;
    logic [DATA_W-1:0]      scap_reg;
    logic [FSUM_W-FRIC_FRAC-1:0] fr_full;
    logic [STRESS_W-1:0]    fr;
    logic [STRESS_W:0]      scap_raw;
    logic [DATA_W-1:0]      scap_next;
    side_t                  side_reg [0:DIV_LAT-1];
    logic [DIV_LAT-1:0]     sv_reg;
    logic                   c0_v_reg, c1_v_reg, c2_v_reg, o_v_reg;
    logic [DATA_W-1:0]      util_reg, util_next;
    logic                   fail_reg;
    logic [QUO_W-1:0]       q_c, q_s, q_t;
    logic [DATA_W-1:0]      r_c, r_s, r_t, best;

    always_comb
    begin
        fr_full   = fsum_reg[FSUM_W-1:FRIC_FRAC];
        fr        = (fr_full[FSUM_W-FRIC_FRAC-1:STRESS_W] != '0) ? {STRESS_W{1'b1}}
                                                                 : fr_full[STRESS_W-1:0];
        scap_raw  = (STRESS_W+1)'(cfg.coh) + {1'b0, fr};
        scap_next = (scap_raw > (STRESS_W+1)'(cfg.maxsh)) ? cfg.maxsh
                                                          : scap_raw[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_v_reg <= 1'b0;
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            sv_reg   <= '0;
            o_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            c0_v_reg <= in_v;
            c1_v_reg <= c0_v_reg;
            c2_v_reg <= c1_v_reg;
            sv_reg   <= {sv_reg[DIV_LAT-2:0], c2_v_reg};
            o_v_reg  <= sv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg.pc   <= relief.pc;
            c0_reg.pt   <= relief.pt;
            c0_reg.ss   <= relief.ss;
            c0_reg.fail <= relief.fail;
            pfh_reg     <= cfg.fric * relief.mc[STRESS_W-1:HALF_W];
            pfl_reg     <= cfg.fric * relief.mc[HALF_W-1:0];
            c1_reg      <= c0_reg;
            fsum_reg    <= (FSUM_W'(pfh_reg) << HALF_W) + FSUM_W'(pfl_reg);
            c2_reg      <= c1_reg;
            scap_reg    <= scap_next;
            side_reg[0].cs_nz <= cfg.comp != '0;
            side_reg[0].sc_nz <= scap_reg != '0;
            side_reg[0].ts_nz <= cfg.tens != '0;
            side_reg[0].fail  <= c2_reg.fail
                              || (cfg.comp == '0 && c2_reg.pc != '0)
                              || (scap_reg == '0 && c2_reg.ss != '0)
                              || (cfg.tens == '0 && c2_reg.pt != '0);
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            util_reg <= util_next;
            fail_reg <= side_reg[DIV_LAT-1].fail;
        end
    end

    jsu_div u_div_c (.clk(clk), .en(en), .num(NUM_W'(c2_reg.pc) << FRAC_BITS),
                     .den(DEN_W'(cfg.comp)), .quo(q_c));
    jsu_div u_div_s (.clk(clk), .en(en), .num(NUM_W'(c2_reg.ss) << FRAC_BITS),
                     .den(DEN_W'(scap_reg)), .quo(q_s));
    jsu_div u_div_t (.clk(clk), .en(en), .num(NUM_W'(c2_reg.pt) << FRAC_BITS),
                     .den(DEN_W'(cfg.tens)), .quo(q_t));

    always_comb
    begin
        r_c  = side_reg[DIV_LAT-1].cs_nz ? clamp_ratio(q_c) : '0;
        r_s  = side_reg[DIV_LAT-1].sc_nz ? clamp_ratio(q_s) : '0;
        r_t  = side_reg[DIV_LAT-1].ts_nz ? clamp_ratio(q_t) : '0;
        best = (r_s > r_c) ? r_s : r_c;
        best = (r_t > best) ? r_t : best;
        util_next = side_reg[DIV_LAT-1].fail ? {DATA_W{1'b1}} : best;
    end

    assign out_v  = o_v_reg;
    assign util   = util_reg;
    assign failed = fail_reg;

endmodule
`default_nettype wire
